@@ design/ms1dp_pkg.sv @@
// ----------------------------------------------------------------------------
// ms1dp_pkg: shared types and constants for the minimum-steps-to-one block
// Holds the controller state encoding, the command and status bundles
// between controller and datapath, and the fixed field widths.
// ----------------------------------------------------------------------------
package ms1dp_pkg;

    localparam int QUERY_W = 16;
    localparam int STEP_W  = 6;
    localparam int LIM_W   = 17;   // wide enough for any query and for MAX_N up to 2^17 - 1

    localparam logic [STEP_W-1:0] STEP_MAX = 6'd63;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_FILL,
        ST_DRAIN,
        ST_READ,
        ST_WAIT,
        ST_RESP
    } t_state;

    typedef enum logic [1:0] {
        ANS_NONE,
        ANS_ERR,
        ANS_FILL,
        ANS_MEM
    } t_ans_sel;

    typedef struct packed {
        logic     load_query;
        logic     issue;
        logic     rd_query;
        t_ans_sel ans_sel;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic query_err;
        logic need_fill;
        logic fill_last;
        logic out_free;
    } t_dp_status;

endpackage

@@ design/ms1dp_ctrl.sv @@
// ----------------------------------------------------------------------------
// ms1dp_ctrl: sequencer for the minimum-steps-to-one block
// Takes one query at a time, decides between error, table extension and a
// direct table read, and hands the answer to the output register.
// ----------------------------------------------------------------------------
module ms1dp_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  ms1dp_pkg::t_dp_status i_status,
    output ms1dp_pkg::t_dp_cmd    o_cmd
);

    ms1dp_pkg::t_state r_state;
    ms1dp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ms1dp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_cmd.load_query = 1'b0;
        o_cmd.issue      = 1'b0;
        o_cmd.rd_query   = 1'b0;
        o_cmd.ans_sel    = ms1dp_pkg::ANS_NONE;
        o_cmd.out_load   = 1'b0;
        o_in_stall       = 1'b1;
        unique case (r_state)
            ms1dp_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_query = 1'b1;
                    n_state          = ms1dp_pkg::ST_CHECK;
                end
            end
            ms1dp_pkg::ST_CHECK: begin
                if (i_status.query_err) begin
                    o_cmd.ans_sel = ms1dp_pkg::ANS_ERR;
                    n_state       = ms1dp_pkg::ST_RESP;
                end else if (i_status.need_fill) begin
                    n_state = ms1dp_pkg::ST_FILL;
                end else begin
                    n_state = ms1dp_pkg::ST_READ;
                end
            end
            ms1dp_pkg::ST_FILL: begin
                // one new entry enters the fill pipe each cycle
                o_cmd.issue = 1'b1;
                if (i_status.fill_last) begin
                    n_state = ms1dp_pkg::ST_DRAIN;
                end
            end
            ms1dp_pkg::ST_DRAIN: begin
                // the last entry written is the answer
                o_cmd.ans_sel = ms1dp_pkg::ANS_FILL;
                n_state       = ms1dp_pkg::ST_RESP;
            end
            ms1dp_pkg::ST_READ: begin
                o_cmd.rd_query = 1'b1;
                n_state        = ms1dp_pkg::ST_WAIT;
            end
            ms1dp_pkg::ST_WAIT: begin
                o_cmd.ans_sel = ms1dp_pkg::ANS_MEM;
                n_state       = ms1dp_pkg::ST_RESP;
            end
            ms1dp_pkg::ST_RESP: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ms1dp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ms1dp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/ms1dp_dpath.sv @@
// ----------------------------------------------------------------------------
// ms1dp_dpath: step table, fill pipeline and output register
// Entry i is built from the previous entry (kept in a register) and the
// entries at i/2 and i/3, read from the table through two read ports. The
// quotients and remainders of the next index advance by counting.
// ----------------------------------------------------------------------------
module ms1dp_dpath #(
    parameter int MAX_N = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [ms1dp_pkg::QUERY_W-1:0] i_query_value,
    input  ms1dp_pkg::t_dp_cmd            i_cmd,
    output ms1dp_pkg::t_dp_status         o_status,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ms1dp_pkg::STEP_W-1:0]  o_step_count,
    output logic                          o_out_of_range
);

    localparam int IDX_W = $clog2(MAX_N + 1);
    localparam int CNT_W = $clog2(MAX_N + 2);
    localparam logic [ms1dp_pkg::LIM_W-1:0] MAX_N_L = ms1dp_pkg::LIM_W'(MAX_N);

    logic [ms1dp_pkg::STEP_W-1:0] r_table [0:MAX_N];

    logic [ms1dp_pkg::QUERY_W-1:0] r_query;

    // next index to fill and its division state
    logic [CNT_W-1:0] r_next;
    logic [CNT_W-1:0] r_q2;
    logic             r_odd;
    logic [CNT_W-1:0] r_q3;
    logic [1:0]       r_m3;
    logic [ms1dp_pkg::STEP_W-1:0] r_last;

    logic [ms1dp_pkg::STEP_W-1:0] r_rd_a;
    logic [ms1dp_pkg::STEP_W-1:0] r_rd_b;
    logic                         r_a_one;
    logic                         r_b_one;

    logic             r_s2_vld;
    logic [IDX_W-1:0] r_s2_idx;
    logic             r_s2_even;
    logic             r_s2_div3;

    logic [ms1dp_pkg::STEP_W-1:0] r_ans;
    logic                         r_err;

    logic                         r_out_vld;
    logic [ms1dp_pkg::STEP_W-1:0] r_out_step;
    logic                         r_out_err;

    logic [IDX_W-1:0]             addr_a;
    logic                         a_one;
    logic [ms1dp_pkg::STEP_W-1:0] val_a;
    logic [ms1dp_pkg::STEP_W-1:0] val_b;
    logic [ms1dp_pkg::STEP_W-1:0] best_min;
    logic [ms1dp_pkg::STEP_W-1:0] best;
    logic [ms1dp_pkg::LIM_W-1:0]  query_l;
    logic [ms1dp_pkg::LIM_W-1:0]  next_l;

    assign query_l = ms1dp_pkg::LIM_W'(r_query);
    assign next_l  = ms1dp_pkg::LIM_W'(r_next);

    assign o_status.query_err = (r_query == '0) || (query_l > MAX_N_L);
    assign o_status.need_fill = (query_l >= next_l);
    assign o_status.fill_last = (query_l == next_l);
    assign o_status.out_free  = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_query <= i_query_value;
        end
    end

    // port A serves i/2 while filling and the query itself on a direct read
    always_comb begin
        if (i_cmd.rd_query) begin
            addr_a = IDX_W'(r_query);
            a_one  = (r_query == ms1dp_pkg::QUERY_W'(1));
        end else begin
            addr_a = IDX_W'(r_q2);
            a_one  = (r_q2 == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_a  <= r_table[addr_a];
        r_rd_b  <= r_table[IDX_W'(r_q3)];
        r_a_one <= a_one;
        r_b_one <= (r_q3 == CNT_W'(1));
    end

    // entry one is never written: it reads as zero
    assign val_a = r_a_one ? '0 : r_rd_a;
    assign val_b = r_b_one ? '0 : r_rd_b;

    always_comb begin
        best_min = r_last;
        if (r_s2_even && (val_a < best_min)) begin
            best_min = val_a;
        end
        if (r_s2_div3 && (val_b < best_min)) begin
            best_min = val_b;
        end
        best = (best_min == ms1dp_pkg::STEP_MAX) ? ms1dp_pkg::STEP_MAX
                                                 : best_min + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_vld) begin
            r_table[r_s2_idx] <= best;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_idx  <= IDX_W'(r_next);
        r_s2_even <= !r_odd;
        r_s2_div3 <= (r_m3 == 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next   <= CNT_W'(2);
            r_q2     <= CNT_W'(1);
            r_odd    <= 1'b0;
            r_q3     <= '0;
            r_m3     <= 2'd2;
            r_last   <= '0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= i_cmd.issue;
            if (i_cmd.issue) begin
                r_next <= r_next + 1'b1;
                r_odd  <= !r_odd;
                if (r_odd) begin
                    r_q2 <= r_q2 + 1'b1;
                end
                if (r_m3 == 2'd2) begin
                    r_m3 <= 2'd0;
                    r_q3 <= r_q3 + 1'b1;
                end else begin
                    r_m3 <= r_m3 + 1'b1;
                end
            end
            if (r_s2_vld) begin
                r_last <= best;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.ans_sel)
            ms1dp_pkg::ANS_ERR: begin
                r_ans <= '0;
                r_err <= 1'b1;
            end
            ms1dp_pkg::ANS_FILL: begin
                r_ans <= best;
                r_err <= 1'b0;
            end
            ms1dp_pkg::ANS_MEM: begin
                r_ans <= val_a;
                r_err <= 1'b0;
            end
            default: begin
                r_ans <= r_ans;
                r_err <= r_err;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_step <= r_ans;
            r_out_err  <= r_err;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_step_count   = r_out_step;
    assign o_out_of_range = r_out_err;

    a_issue_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.issue |-> (next_l <= query_l) && !o_status.query_err)
        else $error("fill issued beyond the query");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> o_status.out_free)
        else $error("output register overwritten while held");

    a_fill_answer_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.ans_sel == ms1dp_pkg::ANS_FILL) |-> r_s2_vld && (next_l == query_l + 1'b1))
        else $error("fill answer taken without the last entry in flight");

    a_mark_moves_on_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_next != $past(r_next)) |-> $past(i_cmd.issue))
        else $error("fill mark moved without an issue");

endmodule

@@ design/min_steps_to_one_dp.sv @@
// ----------------------------------------------------------------------------
// min_steps_to_one_dp: fewest steps to bring a number down to one
// Answers each query from a step table that is extended bottom-up on demand
// and kept across queries behind a fill mark.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_stall   i_query_value[15:0]
//  out      output     o_out_valid / i_out_stall o_step_count[5:0], o_out_of_range
//
//  From one accepted beat to the next: an out-of-range query passes the states
//  IDLE, CHECK and RESP; one at or below the fill mark IDLE, CHECK, READ, WAIT,
//  RESP; one above the mark IDLE, CHECK, FILL, DRAIN, RESP. In FILL the fill pipe
//  writes one table entry per cycle, set by the two table read ports and one write.
//  After reset the mark is one; the table needs no clearing pass.
//  A result held by i_out_stall sits in the output register while the next
//  beat is taken; a second result then waits until that register frees.
// ----------------------------------------------------------------------------
module min_steps_to_one_dp #(
    parameter int MAX_N = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [ms1dp_pkg::QUERY_W-1:0] i_query_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ms1dp_pkg::STEP_W-1:0]  o_step_count,
    output logic                          o_out_of_range
);

    ms1dp_pkg::t_dp_cmd    cmd;
    ms1dp_pkg::t_dp_status status;

    ms1dp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ms1dp_dpath #(
        .MAX_N (MAX_N)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_query_value  (i_query_value),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_step_count   (o_step_count),
        .o_out_of_range (o_out_of_range)
    );

endmodule

@@ tb/min_steps_to_one_dp_tb.sv @@
// ----------------------------------------------------------------------------
// min_steps_to_one_dp_tb: self-checking bench for the minimum-steps-to-one block
// Sends directed and random queries through the valid/stall input channel,
// predicts each answer from a local step table with its own fill mark, and
// checks every output beat in order against the predicted answers.
// ----------------------------------------------------------------------------
module min_steps_to_one_dp_tb;

    localparam int                QUERY_W  = ms1dp_pkg::QUERY_W;
    localparam int                STEP_W   = ms1dp_pkg::STEP_W;
    localparam logic [STEP_W-1:0] STEP_MAX = ms1dp_pkg::STEP_MAX;

    localparam int          MAX_N            = 4096;
    localparam int          LONG_HOLD_AT     = 30;      // results seen before the long hold
    localparam int          LONG_HOLD_CYCLES = 300;
    localparam int          QUIET_FIRST      = 90;      // results with no receiver stall
    localparam int          QUIET_LAST       = 120;
    localparam int          TAIL_CYCLES      = 50;
    localparam int unsigned RUN_LIMIT        = 2000000;

    typedef struct {
        logic [QUERY_W-1:0] query;
        int unsigned        gap;
        bit                 drain_first;
    } t_query_item;

    typedef struct {
        logic [QUERY_W-1:0] query;
        logic [STEP_W-1:0]  steps;
        logic               oor;
    } t_answer;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic [QUERY_W-1:0] query_value = '0;
    logic               out_stall   = 1'b0;
    logic               in_stall;
    logic               out_valid;
    logic [STEP_W-1:0]  step_count;
    logic               out_of_range;

    t_query_item query_fifo[$];
    t_answer     answer_fifo[$];

    // local copy of the block's table and fill mark
    logic [STEP_W-1:0] step_memo [0:MAX_N];
    int unsigned       memo_mark = 1;

    int unsigned gap_left       = 0;
    int unsigned hold_left      = 0;
    bit          long_hold_done = 1'b0;
    int          n_queued       = 0;
    int          n_accepted     = 0;
    int          n_results      = 0;
    int          n_errors       = 0;
    int          n_oor          = 0;
    int          n_extends      = 0;
    int          stim_mark      = 1;
    t_query_item next_item;
    t_answer     seen_answer;

    min_steps_to_one_dp #(
        .MAX_N(MAX_N)
    ) u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_query_value  (query_value),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_step_count   (step_count),
        .o_out_of_range (out_of_range)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Extend the local table up to n when needed, then look n up.
    function automatic t_answer predict_steps(input logic [QUERY_W-1:0] n);
        t_answer          ans;
        int unsigned      idx;
        logic [STEP_W:0]  best;
        ans.query = n;
        ans.steps = '0;
        ans.oor   = 1'b1;
        if (n == 0 || int'(n) > MAX_N) begin
            n_oor++;
            return ans;
        end
        for (idx = memo_mark + 1; idx <= 32'(n); idx++) begin
            best = {1'b0, step_memo[idx-1]};
            if (idx % 2 == 0 && step_memo[idx/2] < best)
                best = {1'b0, step_memo[idx/2]};
            if (idx % 3 == 0 && step_memo[idx/3] < best)
                best = {1'b0, step_memo[idx/3]};
            best = best + 1'b1;
            if (best > STEP_MAX)
                best = {1'b0, STEP_MAX};
            step_memo[idx] = best[STEP_W-1:0];
        end
        if (32'(n) > memo_mark) begin
            memo_mark = 32'(n);
            n_extends++;
        end
        ans.steps = step_memo[n];
        ans.oor   = 1'b0;
        return ans;
    endfunction

    // Queue one query; the gap is the idle time before it is offered.
    task automatic add_query(input logic [QUERY_W-1:0] q, input bit drain);
        t_query_item item;
        int unsigned r;
        r = $urandom_range(0, 99);
        item.query       = q;
        item.drain_first = drain;
        if (n_queued >= 40 && n_queued < 80)
            item.gap = 0;
        else if (r < 60)
            item.gap = 0;
        else if (r < 90)
            item.gap = $urandom_range(1, 3);
        else
            item.gap = $urandom_range(8, 30);
        query_fifo.push_back(item);
        n_queued++;
        if (q != 0 && int'(q) <= MAX_N && int'(q) > stim_mark)
            stim_mark = int'(q);
    endtask

    // Input driver: hold the beat while stalled, else advance to the next item.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                answer_fifo.push_back(predict_steps(query_value));
                n_accepted++;
            end
            if (!in_valid || !in_stall) begin
                if (gap_left != 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (query_fifo.size() != 0 &&
                             !(query_fifo[0].drain_first && answer_fifo.size() != 0)) begin
                    next_item = query_fifo.pop_front();
                    in_valid    <= 1'b1;
                    query_value <= next_item.query;
                    if (query_fifo.size() != 0)
                        gap_left = query_fifo[0].gap;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor and receiver stall pattern.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid === 1'b1 && !out_stall) begin
                n_results++;
                if (answer_fifo.size() == 0) begin
                    $display("%0t: result with nothing expected: step_count %0d out_of_range %0b",
                             $time, step_count, out_of_range);
                    n_errors++;
                end else begin
                    seen_answer = answer_fifo.pop_front();
                    if (step_count !== seen_answer.steps) begin
                        $display("%0t: query %0d step_count expected %0d, got %0d",
                                 $time, seen_answer.query, seen_answer.steps, step_count);
                        n_errors++;
                    end
                    if (out_of_range !== seen_answer.oor) begin
                        $display("%0t: query %0d out_of_range expected %0b, got %0b",
                                 $time, seen_answer.query, seen_answer.oor, out_of_range);
                        n_errors++;
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (n_results >= LONG_HOLD_AT && !long_hold_done) begin
                // hold off long enough for the block to back up into its input
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end else if (n_results >= QUIET_FIRST && n_results < QUIET_LAST) begin
                out_stall <= 1'b0;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: begin
                        out_stall <= 1'b0;
                    end
                    9: begin
                        hold_left = $urandom_range(7, 29);
                        out_stall <= 1'b1;
                    end
                    default: begin
                        hold_left = $urandom_range(0, 2);
                        out_stall <= 1'b1;
                    end
                endcase
            end
        end
    end

    initial begin
        #(RUN_LIMIT * 10);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int unsigned r;
        int          k;
        int          v;
        step_memo[1] = '0;

        // directed: range edges, repeats, mark-equal and mark-plus-one queries
        add_query(16'd0, 1'b0);
        add_query(16'd1, 1'b0);
        add_query(16'd1, 1'b0);
        add_query(16'd2, 1'b0);
        add_query(16'd3, 1'b0);
        add_query(16'd4, 1'b0);
        add_query(16'd6, 1'b0);
        add_query(16'd9, 1'b0);
        add_query(16'd27, 1'b0);
        add_query(16'd7, 1'b0);
        add_query(16'd27, 1'b1);
        add_query(16'd28, 1'b0);
        add_query(16'd100, 1'b0);
        add_query(16'd97, 1'b0);
        add_query(16'd4097, 1'b1);
        add_query(16'hFFFF, 1'b0);
        add_query(16'h8000, 1'b0);
        add_query(16'h5555, 1'b0);
        add_query(16'hAAAA, 1'b0);
        add_query(16'd0, 1'b0);
        add_query(16'd243, 1'b0);

        for (k = 0; k < 115; k++) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                add_query(QUERY_W'($urandom_range(1, stim_mark)), k == 70);
            end else if (r < 75) begin
                v = stim_mark + int'($urandom_range(1, 40));
                add_query(QUERY_W'((v > MAX_N) ? MAX_N : v), 1'b0);
            end else if (r < 82) begin
                v = stim_mark + int'($urandom_range(41, 400));
                add_query(QUERY_W'((v > MAX_N) ? MAX_N : v), 1'b0);
            end else if (r < 90) begin
                add_query(QUERY_W'($urandom_range(MAX_N + 1, 65535)), 1'b0);
            end else if (r < 95) begin
                add_query(16'd0, 1'b0);
            end else begin
                add_query(QUERY_W'($urandom_range(0, 65535)), 1'b0);
            end
        end
        add_query(QUERY_W'(MAX_N), 1'b0);
        add_query(QUERY_W'(MAX_N - 1), 1'b0);
        add_query(QUERY_W'(MAX_N + 1), 1'b0);
        add_query(16'd1, 1'b0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (query_fifo.size() != 0 || in_valid || answer_fifo.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (answer_fifo.size() != 0) begin
            $display("%0t: %0d answers never arrived", $time, answer_fifo.size());
            n_errors++;
        end
        $display("Sent %0d queries (%0d out of range), checked %0d answers, %0d mismatches.",
                 n_accepted, n_oor, n_results, n_errors);
        $display("Table grew %0d times to a mark of %0d, with a %0d-cycle receiver hold.",
                 n_extends, memo_mark, LONG_HOLD_CYCLES);
        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
